// ----- hdl/xdm_pkg.sv -----
// shared widths, constants and pipeline depth for the x-drive wheel mixer
package xdm_pkg;

    localparam int ANGLE_BITS     = 12;
    localparam int TRIG_FRAC_BITS = 14;

    localparam int CMD_W     = 8;
    localparam int HEADING_W = ANGLE_BITS;
    localparam int SPD_W     = 11;
    localparam int LANES     = 4;
    localparam int IN_FIELDS = 6;

    localparam int IN_W  = ((IN_FIELDS * CMD_W + HEADING_W + 7) / 8) * 8;
    localparam int OUT_W = ((LANES * SPD_W + 7) / 8) * 8;

    localparam int QUARTER_BITS = ANGLE_BITS - 2;
    localparam int ROM_DEPTH    = (1 << (QUARTER_BITS - 1)) + 1;
    localparam int ROM_AW       = QUARTER_BITS;
    localparam int MAGT_W       = TRIG_FRAC_BITS + 1;
    localparam int TRIG_W       = TRIG_FRAC_BITS + 2;

    localparam int SUM_W   = CMD_W + 2;
    localparam int PROD_W  = SUM_W + TRIG_W;
    localparam int WHEEL_W = PROD_W + 2;
    localparam int MAG_W   = WHEEL_W - 1;

    localparam int SCALE = 600;
    localparam int QUO_W = 10;
    localparam int NUM_W = MAG_W + QUO_W;

    localparam int FRONT_STAGES = 5;
    localparam int NSTAGES      = FRONT_STAGES + QUO_W;

    localparam logic [MAG_W-1:0] LIMIT = MAG_W'(127) << TRIG_FRAC_BITS;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1) << TRIG_FRAC_BITS;

endpackage

// ----- hdl/xdm_trig.sv -----
// heading sine and cosine: quarter-wave table lookup with quadrant symmetry
module xdm_trig (
    input  logic                               clk,
    input  logic                               en,
    input  logic        [xdm_pkg::HEADING_W-1:0] heading,
    output logic signed [xdm_pkg::TRIG_W-1:0]    sin_val,
    output logic signed [xdm_pkg::TRIG_W-1:0]    cos_val
);
    import xdm_pkg::*;

    typedef logic [2*MAGT_W-1:0] trig_rom_t [ROM_DEPTH];
    typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quad_t;

    localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;
    localparam logic [63:0] PI_Q32  = 64'd13493037705;
    localparam logic [63:0] HALF_LSB = 64'd1 << (31 - TRIG_FRAC_BITS);

    // taylor series in q32 for every folded remainder, rounded to the table format
    function automatic trig_rom_t build_trig_rom();
        trig_rom_t rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] sv;
        logic [63:0] cv;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            x  = (64'(i) * PI_Q32 + (64'd1 << (ANGLE_BITS - 2))) >> (ANGLE_BITS - 1);
            x2 = (x * x) >> 32;
            t  = Q32_ONE;
            t  = Q32_ONE - (((x2 * t) >> 32) / 64'd110);
            t  = Q32_ONE - (((x2 * t) >> 32) / 64'd72);
            t  = Q32_ONE - (((x2 * t) >> 32) / 64'd42);
            t  = Q32_ONE - (((x2 * t) >> 32) / 64'd20);
            t  = Q32_ONE - (((x2 * t) >> 32) / 64'd6);
            sv = ((((x * t) >> 32) + HALF_LSB) >> (32 - TRIG_FRAC_BITS));
            t  = Q32_ONE;
            t  = Q32_ONE - (((x2 * t) >> 32) / 64'd132);
            t  = Q32_ONE - (((x2 * t) >> 32) / 64'd90);
            t  = Q32_ONE - (((x2 * t) >> 32) / 64'd56);
            t  = Q32_ONE - (((x2 * t) >> 32) / 64'd30);
            t  = Q32_ONE - (((x2 * t) >> 32) / 64'd12);
            t  = Q32_ONE - (((x2 * t) >> 32) / 64'd2);
            cv = ((t + HALF_LSB) >> (32 - TRIG_FRAC_BITS));
            rom[i] = {cv[MAGT_W-1:0], sv[MAGT_W-1:0]};
        end
        return rom;
    endfunction

    localparam trig_rom_t TRIG_ROM = build_trig_rom();

    localparam logic [QUARTER_BITS:0] QUARTER = (QUARTER_BITS+1)'(1) << QUARTER_BITS;
    localparam logic [QUARTER_BITS-1:0] EIGHTH = QUARTER_BITS'(1) << (QUARTER_BITS - 1);

    logic [QUARTER_BITS-1:0] rem;
    logic                    fold;
    logic [QUARTER_BITS:0]   mirror;
    logic [ROM_AW-1:0]       rom_addr;

    logic [2*MAGT_W-1:0] rom_q_reg;
    quad_t               quad_reg;
    logic                fold_reg;

    logic [MAGT_W-1:0]        sin_mag;
    logic [MAGT_W-1:0]        cos_mag;
    logic signed [TRIG_W-1:0] sin_pos;
    logic signed [TRIG_W-1:0] cos_pos;

    assign rem      = heading[QUARTER_BITS-1:0];
    assign fold     = rem > EIGHTH;
    assign mirror   = QUARTER - {1'b0, rem};
    assign rom_addr = fold ? mirror[ROM_AW-1:0] : rem;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rom_q_reg <= TRIG_ROM[rom_addr];
            quad_reg  <= quad_t'(heading[ANGLE_BITS-1:ANGLE_BITS-2]);
            fold_reg  <= fold;
        end
    end

    assign sin_mag = fold_reg ? rom_q_reg[2*MAGT_W-1:MAGT_W] : rom_q_reg[MAGT_W-1:0];
    assign cos_mag = fold_reg ? rom_q_reg[MAGT_W-1:0] : rom_q_reg[2*MAGT_W-1:MAGT_W];
    assign sin_pos = signed'({1'b0, sin_mag});
    assign cos_pos = signed'({1'b0, cos_mag});

    always_comb
    begin
        case (quad_reg)
            QUAD_0:
            begin
                sin_val = sin_pos;
                cos_val = cos_pos;
            end
            QUAD_90:
            begin
                sin_val = cos_pos;
                cos_val = -sin_pos;
            end
            QUAD_180:
            begin
                sin_val = -sin_pos;
                cos_val = -cos_pos;
            end
            default:
            begin
                sin_val = -cos_pos;
                cos_val = sin_pos;
            end
        endcase
    end

endmodule

// ----- hdl/xdm_div.sv -----
// pipelined restoring divider, one quotient bit per stage, four lanes sharing a divisor
module xdm_div (
    input  logic                              clk,
    input  logic        [xdm_pkg::QUO_W-1:0]  en,
    input  logic        [xdm_pkg::NUM_W-1:0]  num [xdm_pkg::LANES],
    input  logic        [xdm_pkg::MAG_W-1:0]  den,
    input  logic        [xdm_pkg::LANES-1:0]  neg,
    output logic signed [xdm_pkg::SPD_W-1:0]  speed [xdm_pkg::LANES]
);
    import xdm_pkg::*;

    localparam int LAST = QUO_W - 1;

    logic [NUM_W-1:0] rem_reg [LAST][LANES];
    logic [QUO_W-1:0] quo_reg [LAST][LANES];
    logic [MAG_W-1:0] den_reg [LAST];
    logic [LANES-1:0] neg_reg [LAST];
    logic signed [SPD_W-1:0] spd_reg [LANES];

    logic [NUM_W-1:0] rem_src [QUO_W][LANES];
    logic [QUO_W-1:0] quo_src [QUO_W][LANES];
    logic [MAG_W-1:0] den_src [QUO_W];
    logic [LANES-1:0] neg_src [QUO_W];

    logic [NUM_W-1:0] shifted [QUO_W];
    logic             take    [QUO_W][LANES];
    logic [NUM_W-1:0] rem_next [LAST][LANES];
    logic [QUO_W-1:0] quo_next [QUO_W][LANES];
    logic signed [SPD_W-1:0] spd_next [LANES];

    always_comb
    begin
        den_src[0] = den;
        neg_src[0] = neg;
        for (int l = 0; l < LANES; l++)
        begin
            rem_src[0][l] = num[l];
            quo_src[0][l] = '0;
        end
        for (int s = 1; s < QUO_W; s++)
        begin
            den_src[s] = den_reg[s-1];
            neg_src[s] = neg_reg[s-1];
            for (int l = 0; l < LANES; l++)
            begin
                rem_src[s][l] = rem_reg[s-1][l];
                quo_src[s][l] = quo_reg[s-1][l];
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < QUO_W; s++)
        begin
            shifted[s] = NUM_W'(den_src[s]) << (QUO_W - 1 - s);
            for (int l = 0; l < LANES; l++)
            begin
                take[s][l]     = rem_src[s][l] >= shifted[s];
                quo_next[s][l] = {quo_src[s][l][QUO_W-2:0], take[s][l]};
            end
        end
        for (int s = 0; s < LAST; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_next[s][l] = take[s][l] ? rem_src[s][l] - shifted[s] : rem_src[s][l];
            end
        end
        for (int l = 0; l < LANES; l++)
        begin
            spd_next[l] = neg_src[LAST][l] ? -SPD_W'(quo_next[LAST][l])
                                           : SPD_W'(quo_next[LAST][l]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < LAST; s++)
        begin
            if (en[s])
            begin
                den_reg[s] <= den_src[s];
                neg_reg[s] <= neg_src[s];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l] <= rem_next[s][l];
                    quo_reg[s][l] <= quo_next[s][l];
                end
            end
        end
        if (en[LAST])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                spd_reg[l] <= spd_next[l];
            end
        end
    end

    assign speed = spd_reg;

endmodule

// ----- hdl/holonomic_x_drive_mixer.sv -----
// top level of the x-drive wheel mixer with optional field-oriented rotation
//
//  channel   | direction | handshake                       | payload
//  ----------+-----------+---------------------------------+-----------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready   | six commands and heading
//  m_axis    | out       | m_axis_tvalid / m_axis_tready   | four wheel speeds
//  cfg       | in        | cfg_valid / cfg_ready           | field_oriented bit
//
//  one transaction per cycle in, one per cycle out while m_axis_tready is high; the stages are:
//  input capture with the trig table read, products, mixing, magnitudes,
//  maximum and scale, then ten divider stages of one quotient bit each
//  reset clears the stage valid bits and field_oriented
//  every stage holds while the stage after it is full and stalled, so bubbles
//  are squeezed out and nothing is lost or repeated
module holonomic_x_drive_mixer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // drv_fwd, drv_str, drv_turn, aut_fwd, aut_str, aut_turn, heading, zero pad
    input  logic [xdm_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // front_left_speed, front_right_speed, back_left_speed, back_right_speed, zero pad
    output logic [xdm_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);
    import xdm_pkg::*;

    localparam int HEAD_LO = IN_FIELDS * CMD_W;
    localparam int DIV_LO  = FRONT_STAGES;
    localparam logic signed [SPD_W-1:0] SPD_MAX = SPD_W'(SCALE);

    logic [NSTAGES-1:0] stage_valid_reg;
    logic [NSTAGES-1:0] stage_valid_next;
    logic [NSTAGES-1:0] stage_en;
    logic               fo_reg;

    logic signed [CMD_W-1:0] drv_fwd;
    logic signed [CMD_W-1:0] drv_str;
    logic signed [CMD_W-1:0] drv_turn;
    logic signed [CMD_W-1:0] aut_fwd;
    logic signed [CMD_W-1:0] aut_str;
    logic signed [CMD_W-1:0] aut_turn;

    logic signed [SUM_W-1:0] fwd_reg;
    logic signed [SUM_W-1:0] str_reg;
    logic signed [SUM_W-1:0] turn0_reg;

    logic signed [TRIG_W-1:0] sin_val;
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_sel;
    logic signed [TRIG_W-1:0] cos_sel;

    logic signed [PROD_W-1:0] p_sc_reg;
    logic signed [PROD_W-1:0] p_fs_reg;
    logic signed [PROD_W-1:0] p_ss_reg;
    logic signed [PROD_W-1:0] p_fc_reg;
    logic signed [SUM_W-1:0]  turn1_reg;

    logic signed [WHEEL_W-1:0] rot_str;
    logic signed [WHEEL_W-1:0] rot_fwd;
    logic signed [WHEEL_W-1:0] turn_q;
    logic signed [WHEEL_W-1:0] wheel_next [LANES];
    logic signed [WHEEL_W-1:0] wheel_reg  [LANES];

    logic [MAG_W-1:0] mag_next [LANES];
    logic [MAG_W-1:0] mag_reg  [LANES];
    logic [LANES-1:0] neg3_reg;

    logic [MAG_W-1:0] max_lo;
    logic [MAG_W-1:0] max_hi;
    logic [MAG_W-1:0] max_all;
    logic [NUM_W-1:0] num_reg [LANES];
    logic [MAG_W-1:0] den_reg;
    logic [LANES-1:0] neg_reg;

    logic signed [SPD_W-1:0] speed [LANES];

    // handshake and per-stage enables
    assign stage_valid_next = {stage_valid_reg[NSTAGES-2:0], s_axis_tvalid};

    always_comb
    begin
        stage_en[NSTAGES-1] = !stage_valid_reg[NSTAGES-1] || m_axis_tready;
        for (int i = NSTAGES - 2; i >= 0; i--)
        begin
            stage_en[i] = !stage_valid_reg[i] || stage_en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            fo_reg          <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NSTAGES; i++)
            begin
                if (stage_en[i])
                begin
                    stage_valid_reg[i] <= stage_valid_next[i];
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                fo_reg <= cfg_data;
            end
        end
    end

    assign s_axis_tready = stage_en[0];
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = stage_valid_reg[NSTAGES-1];

    // stage 0: command sums
    assign drv_fwd  = s_axis_tdata[0*CMD_W +: CMD_W];
    assign drv_str  = s_axis_tdata[1*CMD_W +: CMD_W];
    assign drv_turn = s_axis_tdata[2*CMD_W +: CMD_W];
    assign aut_fwd  = s_axis_tdata[3*CMD_W +: CMD_W];
    assign aut_str  = s_axis_tdata[4*CMD_W +: CMD_W];
    assign aut_turn = s_axis_tdata[5*CMD_W +: CMD_W];

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            fwd_reg   <= -(SUM_W'(drv_fwd) + SUM_W'(aut_fwd));
            str_reg   <= -(SUM_W'(drv_str) + SUM_W'(aut_str));
            turn0_reg <= SUM_W'(drv_turn) + SUM_W'(aut_turn);
        end
    end

    xdm_trig u_trig (
        .clk     (clk),
        .en      (stage_en[0]),
        .heading (s_axis_tdata[HEAD_LO +: HEADING_W]),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    // stage 1: rotation products
    assign sin_sel = fo_reg ? sin_val : '0;
    assign cos_sel = fo_reg ? cos_val : TRIG_ONE;

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            p_sc_reg  <= PROD_W'(str_reg) * PROD_W'(cos_sel);
            p_fs_reg  <= PROD_W'(fwd_reg) * PROD_W'(sin_sel);
            p_ss_reg  <= PROD_W'(str_reg) * PROD_W'(sin_sel);
            p_fc_reg  <= PROD_W'(fwd_reg) * PROD_W'(cos_sel);
            turn1_reg <= turn0_reg;
        end
    end

    // stage 2: wheel mix
    assign rot_str = WHEEL_W'(p_sc_reg) - WHEEL_W'(p_fs_reg);
    assign rot_fwd = WHEEL_W'(p_ss_reg) + WHEEL_W'(p_fc_reg);
    assign turn_q  = WHEEL_W'(turn1_reg) <<< TRIG_FRAC_BITS;

    always_comb
    begin
        wheel_next[0] = turn_q - rot_str - rot_fwd;
        wheel_next[1] = turn_q + rot_fwd - rot_str;
        wheel_next[2] = turn_q + rot_str - rot_fwd;
        wheel_next[3] = turn_q + rot_str + rot_fwd;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            wheel_reg <= wheel_next;
        end
    end

    // stage 3: magnitudes and signs
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            mag_next[l] = wheel_reg[l][WHEEL_W-1] ? MAG_W'(-wheel_reg[l])
                                                  : MAG_W'(wheel_reg[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            mag_reg <= mag_next;
            for (int l = 0; l < LANES; l++)
            begin
                neg3_reg[l] <= wheel_reg[l][WHEEL_W-1];
            end
        end
    end

    // stage 4: largest magnitude, divisor and scaled numerators
    assign max_lo  = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
    assign max_hi  = (mag_reg[2] > mag_reg[3]) ? mag_reg[2] : mag_reg[3];
    assign max_all = (max_lo > max_hi) ? max_lo : max_hi;

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            den_reg <= (max_all > LIMIT) ? max_all : LIMIT;
            neg_reg <= neg3_reg;
            for (int l = 0; l < LANES; l++)
            begin
                num_reg[l] <= NUM_W'(mag_reg[l]) * NUM_W'(SCALE);
            end
        end
    end

    xdm_div u_div (
        .clk   (clk),
        .en    (stage_en[NSTAGES-1:DIV_LO]),
        .num   (num_reg),
        .den   (den_reg),
        .neg   (neg_reg),
        .speed (speed)
    );

    assign m_axis_tdata = OUT_W'({speed[3], speed[2], speed[1], speed[0]});

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&stage_valid_reg) && !m_axis_tready)
        else $error("input stalled while the pipeline has room");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> speed[0] <= SPD_MAX && speed[0] >= -SPD_MAX
                       && speed[1] <= SPD_MAX && speed[1] >= -SPD_MAX
                       && speed[2] <= SPD_MAX && speed[2] >= -SPD_MAX
                       && speed[3] <= SPD_MAX && speed[3] >= -SPD_MAX)
        else $error("wheel speed outside the scaled range");

    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg[4] |-> mag_reg[0] <= max_all && mag_reg[1] <= max_all
                            && mag_reg[2] <= max_all && mag_reg[3] <= max_all)
        else $error("maximum below a wheel magnitude");

endmodule
